/* hw/rtl/gep_pkg.sv */
// Shared types and constants for the new-game event parser.
// No dependencies; imported by every module of the block.
package gep_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned MIN_TAIL     = 4;
  localparam int unsigned LIMIT_RESET  = 512;

  // Final and error status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_NO_TERM    = 3'd2,
    ST_ORDER      = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_OVER_LIMIT = 3'd5
  } status_t;

  // Running comparison of the current name against the previous one
  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  // Control part of one result
  typedef struct packed {
    logic    valid;
    logic    done;
    logic    dup;
    status_t status;
  } res_ctl_t;

endpackage

/* hw/rtl/gep_name_mem.sv */
// Name byte store: one write port, one registered read port.
// Holds the current and the previous name in two banks. Uses gep_pkg.
module gep_name_mem
  import gep_pkg::*;
#(
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/gep_parse.sv */
// Per-byte parse step: header assembly, name ordering, length and budget checks.
// Depends on gep_pkg and gep_name_mem.
module gep_parse
  import gep_pkg::*;
#(
  parameter int unsigned NAME_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic [7:0]                         data_byte,
  input  logic                               last_byte,
  input  logic [15:0]                        name_bytes_limit,
  output logic [31:0]                        res_width,
  output logic [31:0]                        res_height,
  output logic [15:0]                        res_name_index,
  output logic [$clog2(NAME_MAX+2)-1:0]      res_name_length,
  output res_ctl_t                           res_ctl
);

  localparam int unsigned LEN_W = $clog2(NAME_MAX + 2);
  localparam int unsigned IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NAME_MAX);

  logic [15:0]      pos_r, pos_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [LEN_W-1:0] prev_len_r, prev_len_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  cmp_t             cmp_r, cmp_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [15:0]      total_r, total_nxt;
  logic [15:0]      count_r, count_nxt;
  status_t          err_r, err_nxt;
  logic             prev_bank_r, prev_bank_nxt;

  logic             wr_en;
  logic [7:0]       prev_byte;
  logic [16:0]      budget;
  cmp_t             cmp_end;
  logic             accepted;
  logic             rd_bank;
  logic [LEN_W-1:0] rd_len;

  always_comb begin
    pos_nxt       = pos_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    prev_len_nxt  = prev_len_r;
    cur_len_nxt   = cur_len_r;
    cmp_nxt       = cmp_r;
    have_prev_nxt = have_prev_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    prev_bank_nxt = prev_bank_r;
    wr_en         = 1'b0;
    accepted      = 1'b0;
    cmp_end       = cmp_r;
    budget        = {1'b0, total_r} + 17'(cur_len_r) + 17'd1;

    res_name_index  = '0;
    res_name_length = '0;
    res_ctl.dup     = 1'b0;

    if (pos_r < 16'(4)) begin
      width_nxt = {width_r[23:0], data_byte};
    end else if (pos_r < 16'(HEADER_BYTES)) begin
      height_nxt = {height_r[23:0], data_byte};
    end else if (err_r == ST_OK) begin
      if (data_byte != 8'd0) begin
        if (cmp_r == CMP_EQ) begin
          if (cur_len_r >= prev_len_r) begin
            cmp_nxt = CMP_GT;
          end else if (cur_len_r < LEN_MAX) begin
            if (data_byte < prev_byte) begin
              cmp_nxt = CMP_LT;
            end else if (data_byte > prev_byte) begin
              cmp_nxt = CMP_GT;
            end
          end
        end
        wr_en = fire && (cur_len_r < LEN_MAX);
        if (cur_len_r < LEN_MAX + LEN_W'(1)) begin
          cur_len_nxt = cur_len_r + LEN_W'(1);
        end
      end else begin
        // terminator: close the name
        if (cmp_r == CMP_EQ && cur_len_r < prev_len_r) begin
          cmp_end = CMP_LT;
        end
        if (cmp_end == CMP_LT) begin
          err_nxt = ST_ORDER;
        end else if (cur_len_r > LEN_MAX) begin
          err_nxt = ST_TOO_LONG;
        end else if (budget > 17'(name_bytes_limit)) begin
          err_nxt = ST_OVER_LIMIT;
        end else begin
          accepted        = 1'b1;
          res_name_index  = count_r;
          res_name_length = cur_len_r;
          res_ctl.dup     = have_prev_r && (cmp_end == CMP_EQ);
          if (count_r != 16'hFFFF) begin
            count_nxt = count_r + 16'd1;
          end
          total_nxt     = budget[15:0];
          prev_len_nxt  = cur_len_r;
          have_prev_nxt = 1'b1;
          // current bank becomes the previous name
          prev_bank_nxt = ~prev_bank_r;
        end
        cur_len_nxt = '0;
        cmp_nxt     = CMP_EQ;
      end
    end

    if (pos_r != 16'hFFFF) begin
      pos_nxt = pos_r + 16'd1;
    end

    res_width  = width_nxt;
    res_height = height_nxt;

    res_ctl.valid  = accepted || last_byte;
    res_ctl.done   = last_byte;
    res_ctl.status = ST_OK;
    if (last_byte) begin
      if (pos_r < 16'(HEADER_BYTES + MIN_TAIL - 1)) begin
        res_ctl.status = ST_TOO_SHORT;
      end else if (data_byte != 8'd0) begin
        res_ctl.status = ST_NO_TERM;
      end else begin
        res_ctl.status = err_nxt;
      end
      // event ends: back to the empty state
      pos_nxt       = '0;
      width_nxt     = '0;
      height_nxt    = '0;
      prev_len_nxt  = '0;
      cur_len_nxt   = '0;
      cmp_nxt       = CMP_EQ;
      have_prev_nxt = 1'b0;
      total_nxt     = '0;
      count_nxt     = '0;
      err_nxt       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      prev_len_r  <= '0;
      cur_len_r   <= '0;
      cmp_r       <= CMP_EQ;
      have_prev_r <= 1'b0;
      total_r     <= '0;
      count_r     <= '0;
      err_r       <= ST_OK;
      prev_bank_r <= 1'b0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      prev_len_r  <= prev_len_nxt;
      cur_len_r   <= cur_len_nxt;
      cmp_r       <= cmp_nxt;
      have_prev_r <= have_prev_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      prev_bank_r <= prev_bank_nxt;
    end
  end

  // Prefetch previous_name[cur_len] for the next byte
  assign rd_bank = fire ? prev_bank_nxt : prev_bank_r;
  assign rd_len  = fire ? cur_len_nxt : cur_len_r;

  gep_name_mem #(
    .ADDR_W (IDX_W + 1)
  ) u_name_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({~prev_bank_r, cur_len_r[IDX_W-1:0]}),
    .wr_data (data_byte),
    .rd_addr ({rd_bank, rd_len[IDX_W-1:0]}),
    .rd_data (prev_byte)
  );

endmodule

/* hw/rtl/new_game_event_parser.sv */
// New-game event parser top level: input register, parse step, result register.
// Depends on gep_pkg, gep_parse and gep_name_mem.
//
// Usage:
//   in_*  : one payload byte per request; in_last_byte marks the final byte.
//           Bytes 0-7 are the big-endian width and height, then zero-terminated
//           names follow.
//   out_* : one request per accepted name (sent at its terminator) and one final
//           request per event (out_done_res set, status), merged with a last-byte name.
//   cfg_* : writes name_bytes_limit (reset 512); always ready. The user must
//           write it only while the block is idle; the block does not enforce it.
// Flow: an accepted byte waits in the input register and is parsed from there;
//   its result, if any, is loaded into the result register once that is free.
// Throughput: one byte per cycle unless stalled, set by the single parse step, which
//   reads the stored previous name through a prefetched registered memory port.
// Stall: while the result register is full and out_ready is low, the parse
//   step holds, the input register keeps its byte, and in_ready falls.
// Reset: clears all event state, both valid flags, and the limit to 512.
//   Stored name bytes are not cleared; they are only read after being written.
module new_game_event_parser
  import gep_pkg::*;
#(
  parameter int unsigned NAME_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  // result requests
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_width,
  output logic [31:0]                   out_height,
  output logic [15:0]                   out_name_index,
  output logic [$clog2(NAME_MAX+2)-1:0] out_name_length,
  output logic                          out_duplicate,
  output logic                          out_done_res,
  output logic [2:0]                    out_status,
  // limit register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_name_bytes_limit
);

  localparam int unsigned LEN_W = $clog2(NAME_MAX + 2);

  // input register
  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;

  // result register
  logic             out_vld_r, out_vld_nxt;
  logic [31:0]      width_r;
  logic [31:0]      height_r;
  logic [15:0]      index_r;
  logic [LEN_W-1:0] length_r;
  logic             dup_r;
  logic             done_r;
  status_t          status_r;

  logic [15:0]      limit_r;

  logic             fire;
  logic             load;
  logic [31:0]      p_width;
  logic [31:0]      p_height;
  logic [15:0]      p_index;
  logic [LEN_W-1:0] p_length;
  res_ctl_t         p_ctl;

  // Parse whenever a byte is held and the result register can take a result
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;
  assign load     = fire && p_ctl.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  gep_parse #(
    .NAME_MAX (NAME_MAX)
  ) u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .data_byte        (in_byte_r),
    .last_byte        (in_last_r),
    .name_bytes_limit (limit_r),
    .res_width        (p_width),
    .res_height       (p_height),
    .res_name_index   (p_index),
    .res_name_length  (p_length),
    .res_ctl          (p_ctl)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      width_r  <= p_width;
      height_r <= p_height;
      index_r  <= p_index;
      length_r <= p_length;
      dup_r    <= p_ctl.dup;
      done_r   <= p_ctl.done;
      status_r <= p_ctl.status;
    end
  end

  // limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'(LIMIT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_name_bytes_limit;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_width       = width_r;
  assign out_height      = height_r;
  assign out_name_index  = index_r;
  assign out_name_length = length_r;
  assign out_duplicate   = dup_r;
  assign out_done_res    = done_r;
  assign out_status      = status_r;

endmodule

/* bench/tb_new_game_event_parser.sv */
// Self-checking testbench for new_game_event_parser: random and directed events,
// checked against a built-in bytewise parse predictor. Depends on gep_pkg and the RTL.
`timescale 1ns / 100ps

module tb_new_game_event_parser
  import gep_pkg::*;
();

  localparam int NAME_MAX    = 64;
  localparam int IDLE_PCT    = 26;      // percent of cycles a side sits idle
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int PHASE_BYTES = 170;     // minimum random bytes per limit setting
  localparam int NUM_PHASES  = 7;
  localparam int CYCLE_LIMIT = 200000;

  // one byte request as the sender sees it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_byte_t;

  // one result request as the parser should produce it
  typedef struct {
    logic [31:0] wd;
    logic [31:0] ht;
    logic [15:0] idx;
    logic [6:0]  len;
    logic        dup;
    logic        done;
    status_t     st;
  } parse_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_width;
  logic [31:0] out_height;
  logic [15:0] out_name_index;
  logic [6:0]  out_name_length;
  logic        out_duplicate;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_name_bytes_limit = 16'd0;

  new_game_event_parser #(.NAME_MAX(NAME_MAX)) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_width            (out_width),
    .out_height           (out_height),
    .out_name_index       (out_name_index),
    .out_name_length      (out_name_length),
    .out_duplicate        (out_duplicate),
    .out_done_res         (out_done_res),
    .out_status           (out_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_name_bytes_limit (cfg_name_bytes_limit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parse predictor: mirrors the block's event state, updated per accepted byte
  // ---------------------------------------------------------------------------
  logic [15:0] limit_q = 16'(LIMIT_RESET);
  logic [15:0] ev_pos = '0;          // saturating byte position in the event
  logic [31:0] ev_width = '0;
  logic [31:0] ev_height = '0;
  bit   [7:0]  prev_nm [NAME_MAX];   // last accepted name
  bit   [7:0]  cur_nm  [NAME_MAX];   // name being received
  logic [6:0]  prev_len = '0;
  logic [6:0]  cur_len = '0;         // saturates at NAME_MAX+1
  cmp_t        cmp_st = CMP_EQ;
  logic        have_prev = 1'b0;
  logic [15:0] bytes_used = '0;      // name bytes so far, terminators included
  logic [15:0] name_count = '0;      // accepted names, saturating
  status_t     first_err = ST_OK;

  parse_res_t    awaited_results[$];
  payload_byte_t payload_bytes[$];

  int  mismatches = 0;
  int  limit_writes = 0;
  int  cycles = 0;
  int  hold_asks = 0;
  bit  calm = 1'b0;                  // no random idling on either side
  bit  byte_taken = 1'b0;

  function automatic void restart_event();
    ev_pos     = '0;
    ev_width   = '0;
    ev_height  = '0;
    prev_len   = '0;
    cur_len    = '0;
    cmp_st     = CMP_EQ;
    have_prev  = 1'b0;
    bytes_used = '0;
    name_count = '0;
    first_err  = ST_OK;
  endfunction

  // Returns 1 when the byte produces a result request, filled into r.
  function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                    output parse_res_t r);
    logic [15:0] pos;
    logic        acc;
    int          i;
    pos = ev_pos;
    acc = 1'b0;
    r.idx = '0;
    r.len = '0;
    r.dup = 1'b0;
    if (pos < 4) begin
      ev_width = {ev_width[23:0], b};
    end else if (pos < HEADER_BYTES) begin
      ev_height = {ev_height[23:0], b};
    end else if (first_err == ST_OK) begin
      if (b != 8'h00) begin
        // ordering gets decided at the first differing byte
        if (cmp_st == CMP_EQ) begin
          if (cur_len >= prev_len) begin
            cmp_st = CMP_GT;
          end else if (cur_len < NAME_MAX) begin
            if (b < prev_nm[cur_len]) cmp_st = CMP_LT;
            else if (b > prev_nm[cur_len]) cmp_st = CMP_GT;
          end
        end
        if (cur_len < NAME_MAX) cur_nm[cur_len] = b;
        if (cur_len < NAME_MAX + 1) cur_len++;
      end else begin
        // terminator: a proper prefix of the previous name is lower
        if (cmp_st == CMP_EQ && cur_len < prev_len) cmp_st = CMP_LT;
        if (cmp_st == CMP_LT) begin
          first_err = ST_ORDER;
        end else if (cur_len > NAME_MAX) begin
          first_err = ST_TOO_LONG;
        end else if (32'(bytes_used) + 32'(cur_len) + 1 > 32'(limit_q)) begin
          first_err = ST_OVER_LIMIT;
        end else begin
          acc   = 1'b1;
          r.idx = name_count;
          r.len = cur_len;
          r.dup = have_prev && cmp_st == CMP_EQ;
          if (name_count != 16'hFFFF) name_count++;
          bytes_used = bytes_used + 16'(cur_len) + 16'd1;
          for (i = 0; i < cur_len; i++) prev_nm[i] = cur_nm[i];
          prev_len  = cur_len;
          have_prev = 1'b1;
        end
        cur_len = '0;
        cmp_st  = CMP_EQ;
      end
    end
    if (ev_pos != 16'hFFFF) ev_pos++;

    if (!acc && !lst) return 1'b0;

    r.wd   = ev_width;
    r.ht   = ev_height;
    r.done = lst;
    r.st   = ST_OK;
    if (lst) begin
      if (32'(pos) + 1 < HEADER_BYTES + MIN_TAIL) r.st = ST_TOO_SHORT;
      else if (b != 8'h00) r.st = ST_NO_TERM;
      else r.st = first_err;
      restart_event();
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string fld, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", fld, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sees byte requests, limit writes and result requests at the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    parse_res_t r;
    parse_res_t want;
    if (!rst_n) begin
      byte_taken = 1'b0;
      limit_q    = 16'(LIMIT_RESET);
      restart_event();
    end else begin
      byte_taken = in_valid && in_ready;
      if (byte_taken) begin
        if (parse_byte(in_data_byte, in_last_byte, r)) awaited_results.push_back(r);
      end
      // writes only happen while idle, so order against bytes does not matter
      if (cfg_valid && cfg_ready) begin
        limit_q = cfg_name_bytes_limit;
        limit_writes++;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result request: done %0b, status %0d", out_done_res,
                 out_status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("width", want.wd, out_width);
          check_field("height", want.ht, out_height);
          check_field("name_index", 32'(want.idx), 32'(out_name_index));
          check_field("name_length", 32'(want.len), 32'(out_name_length));
          check_field("duplicate", 32'(want.dup), 32'(out_duplicate));
          check_field("done_res", 32'(want.done), 32'(out_done_res));
          check_field("status", 32'(want.st), 32'(out_status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one byte request at a time from payload_bytes, random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    payload_byte_t nb;
    if (rst_n && (!in_valid || byte_taken)) begin
      if (payload_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nb = payload_bytes.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= nb.data;
        in_last_byte <= nb.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_served = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  logic [7:0] evt_bytes[$];
  logic [7:0] last_name[$];
  logic [7:0] this_name[$];

  function automatic logic [7:0] nz_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] header_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic lst);
    payload_bytes.push_back('{data: b, last: lst});
  endtask

  // Next name, built from last_name: mostly in order, some deliberately not.
  task automatic make_name();
    int roll, p, i, len;
    this_name = {};
    roll = $urandom_range(99);
    if (roll < 15) begin
      this_name = last_name;                      // duplicate
    end else if (roll < 30 || (roll < 55 && last_name.size() == 0)) begin
      this_name = last_name;                      // previous name as prefix
      repeat ($urandom_range(1, 4)) this_name.push_back(nz_byte());
    end else if (roll < 55) begin
      p = $urandom_range(0, last_name.size() - 1);
      for (i = 0; i < p; i++) this_name.push_back(last_name[i]);
      if (last_name[p] == 8'hFF) begin
        this_name = last_name;
        this_name.push_back(nz_byte());
      end else begin
        this_name.push_back(8'(last_name[p] + $urandom_range(1, 255 - last_name[p])));
        repeat ($urandom_range(0, 3)) this_name.push_back(nz_byte());
      end
    end else if (roll < 65) begin
      this_name = {};                             // empty name
    end else if (roll < 73) begin
      // lower than the previous name: smaller byte or proper prefix
      if (last_name.size() != 0) begin
        p = $urandom_range(0, last_name.size() - 1);
        for (i = 0; i < p; i++) this_name.push_back(last_name[i]);
        if (last_name[p] > 8'h01 && $urandom_range(1) == 1) begin
          this_name.push_back(8'(last_name[p] - $urandom_range(1, last_name[p] - 1)));
          repeat ($urandom_range(0, 3)) this_name.push_back(nz_byte());
        end
      end
    end else if (roll < 80) begin
      // around the length cap, kept in order
      len = $urandom_range(NAME_MAX - 4, NAME_MAX + 6);
      this_name = last_name;
      while (this_name.size() < len) this_name.push_back(nz_byte());
    end else begin
      repeat ($urandom_range(0, 10)) this_name.push_back(nz_byte());
    end
  endtask

  // Queues one whole event; returns its byte count.
  task automatic queue_event(output int n);
    int roll, names, k, i;
    evt_bytes = {};
    roll = $urandom_range(99);
    if (roll < 8) begin
      // short or garbage event, zero-heavy
      repeat ($urandom_range(1, 14)) begin
        evt_bytes.push_back($urandom_range(1) == 1 ? 8'h00 : 8'($urandom_range(0, 255)));
      end
    end else begin
      repeat (8) evt_bytes.push_back(header_byte());
      names = $urandom_range(0, 6);
      last_name = {};
      for (k = 0; k < names; k++) begin
        make_name();
        for (i = 0; i < this_name.size(); i++) evt_bytes.push_back(this_name[i]);
        evt_bytes.push_back(8'h00);
        last_name = this_name;
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
        // final name left unterminated
        repeat ($urandom_range(1, 5)) evt_bytes.push_back(nz_byte());
      end else if (roll < 15) begin
        evt_bytes.push_back(8'h00);
      end
    end
    for (i = 0; i < evt_bytes.size(); i++) push_byte(evt_bytes[i], i == evt_bytes.size() - 1);
    n = evt_bytes.size();
  endtask

  // Waits until every byte went in and every result came out, then lets the
  // pipeline settle.
  task automatic wait_idle();
    while (payload_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    int seen;
    seen = limit_writes;
    @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_name_bytes_limit <= v;
    while (limit_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed events, then random phases under several limits
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] lim [NUM_PHASES];
    int p, n, budget;
    lim = '{16'd512, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd512, 16'd24};
    lim[4] = 16'($urandom_range(8, 120));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-byte event: too short, width picks up the lone byte
    push_byte(8'hFF, 1'b1);
    // 11 bytes ending on a name byte: too short wins over missing terminator
    for (p = 0; p < 8; p++) push_byte(8'(8'hA5 ^ (p * 8'h3C)), 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    // minimum valid event: empty name, its duplicate, then a one-byte name
    repeat (4) push_byte(8'hFF, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    for (p = 0; p < NUM_PHASES; p++) begin
      // phase boundary: sender stays paused until all results are back
      if (p != 0) write_limit(lim[p]);
      calm = (p == 2);
      budget = 0;
      while (budget < PHASE_BYTES) begin
        queue_event(n);
        budget += n;
      end
      // receiver holds off while the sender keeps offering; block backs up
      if (p == 5) hold_asks++;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_new_game_event_parser: done, clean");
    end else begin
      $display("tb_new_game_event_parser: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_new_game_event_parser: done, errors");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gep_pkg.sv
hw/rtl/gep_name_mem.sv
hw/rtl/gep_parse.sv
hw/rtl/new_game_event_parser.sv
bench/tb_new_game_event_parser.sv
